[rtl/clbp_pkg.sv]
// ----------------------------------------------------------------------------
// clbp_pkg
// Shared constants, types and elaboration-time geometry for the circular LBP
// core.
// ----------------------------------------------------------------------------
package clbp_pkg;

   localparam int PIXEL_W    = 8;
   localparam int CODE_W     = 8;
   localparam int CFG_W      = 11;
   localparam int CSR_ADDR_W = 4;
   localparam int ROW_W      = 10;
   localparam int MAX_HEIGHT = 1024;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   localparam int DEF_RADIUS    = 1;
   localparam int DEF_NEIGHBORS = 8;
   localparam int DEF_MAX_WIDTH = 1024;

   localparam int FIFO_DEPTH = 8;

   localparam int OFF_W    = 4;
   localparam int WEIGHT_W = 10;
   localparam int PROD_W   = 18;
   localparam int SUM_W    = 20;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = CSR_ADDR_W'(1);

   typedef struct packed {
      logic signed [OFF_W-1:0]    fx;
      logic signed [OFF_W-1:0]    cx;
      logic signed [OFF_W-1:0]    fy;
      logic signed [OFF_W-1:0]    cy;
      logic signed [WEIGHT_W-1:0] w1;
      logic signed [WEIGHT_W-1:0] w2;
      logic signed [WEIGHT_W-1:0] w3;
      logic signed [WEIGHT_W-1:0] w4;
   } lbp_geom_type;

   // Q30 magnitude times radius, rounded half away from zero to Q8
   function automatic int q30_to_q8(input longint v, input int radius);
      logic [63:0] mag;
      int          r;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      r   = int'((mag * 64'(radius) + 64'd2097152) >> 22);
      return (v < 0) ? -r : r;
   endfunction

   // Offsets and bilinear weights of one sample point; phi is the angle
   // within its quadrant in Q30
   function automatic lbp_geom_type lbp_geom(input logic [63:0] phi, input int quad,
                                             input int radius);
      logic [63:0]  p2;
      logic [63:0]  ts;
      logic [63:0]  tc;
      longint       ss;
      longint       cs;
      longint       cv;
      longint       sv;
      int           xq;
      int           yq;
      int           fx;
      int           fy;
      int           tx;
      int           ty;
      int           w1;
      int           w2;
      int           w3;
      lbp_geom_type g;
      p2 = (phi * phi) >> 30;
      ts = phi;
      tc = ONE_Q30;
      ss = longint'(phi);
      cs = longint'(ONE_Q30);
      for (int k = 1; k <= 8; k++) begin
         ts = ((ts * p2) >> 30) / 64'((2 * k) * (2 * k + 1));
         tc = ((tc * p2) >> 30) / 64'((2 * k - 1) * (2 * k));
         if ((k % 2) == 1) begin
            ss = ss - longint'(ts);
            cs = cs - longint'(tc);
         end else begin
            ss = ss + longint'(ts);
            cs = cs + longint'(tc);
         end
      end
      unique case (quad % 4)
         0: begin
            cv = cs;
            sv = ss;
         end
         1: begin
            cv = -ss;
            sv = cs;
         end
         2: begin
            cv = -cs;
            sv = -ss;
         end
         default: begin
            cv = ss;
            sv = -cs;
         end
      endcase
      xq = q30_to_q8(cv, radius);
      yq = -q30_to_q8(sv, radius);
      fx = xq >>> 8;
      fy = yq >>> 8;
      tx = xq & 255;
      ty = yq & 255;
      w1 = ((256 - tx) * (256 - ty) + 128) >>> 8;
      w2 = (tx * (256 - ty) + 128) >>> 8;
      w3 = ((256 - tx) * ty + 128) >>> 8;
      g.fx = OFF_W'(fx);
      g.cx = OFF_W'(fx + ((tx != 0) ? 1 : 0));
      g.fy = OFF_W'(fy);
      g.cy = OFF_W'(fy + ((ty != 0) ? 1 : 0));
      g.w1 = WEIGHT_W'(w1);
      g.w2 = WEIGHT_W'(w2);
      g.w3 = WEIGHT_W'(w3);
      g.w4 = WEIGHT_W'(256 - w1 - w2 - w3);
      return g;
   endfunction

endpackage

[rtl/circular_lbp_code_core.sv]
// ----------------------------------------------------------------------------
// circular_lbp_code_core
// Circular local binary pattern over a raster-order 8-bit grey pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while credit is free and returns one LBP code per
// interior pixel via window, product and FIFO registers. Throughput is set by
// the line RAM: each pixel does one read and one write-back of a word holding
// its column of all 2*RADIUS buffered rows, with a forwarding register for
// back-to-back transactions on the same column. Sample geometry and weights
// are fixed at elaboration. An eight-entry output FIFO with credit counting
// keeps the input flowing while results wait to be taken. Configuration is
// applied immediately and should only be written between frames.
// ----------------------------------------------------------------------------
module circular_lbp_code_core
   import clbp_pkg::*;
#(
   parameter int RADIUS    = DEF_RADIUS,
   parameter int NEIGHBORS = DEF_NEIGHBORS,
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CODE_W-1:0]     rsp_code,
   output logic                  rsp_frame_end,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int LINES   = 2 * RADIUS;
   localparam int WSIZE   = 2 * RADIUS + 1;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int SLOT_W  = $clog2(LINES);
   localparam int WORD_W  = LINES * PIXEL_W;
   localparam int CB      = (NEIGHBORS < CODE_W) ? NEIGHBORS : CODE_W;
   localparam int WEXT    = CFG_W + 2;
   localparam int PEND_W  = $clog2(FIFO_DEPTH + 1);
   localparam int FPTR_W  = $clog2(FIFO_DEPTH);
   localparam int RST_WL  = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;
   localparam int RST_HL  = ((RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT) - 1;

   typedef struct packed {
      logic valid;
      logic emit;
      logic frame_end;
   } stage_flags_type;

   // configuration, held as last column / last row index
   logic [COL_W-1:0] width_last_ff;
   logic [COL_W-1:0] width_last_in;
   logic [ROW_W-1:0] height_last_ff;
   logic [ROW_W-1:0] height_last_in;

   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;

   logic accept;
   logic pop;
   logic push;
   logic drop;
   logic col_wrap;
   logic row_wrap;

   stage_flags_type   s1_ff;
   stage_flags_type   s2_ff;
   stage_flags_type   s3_ff;
   stage_flags_type   s1_in;
   logic [PIXEL_W-1:0] s1_px_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [SLOT_W-1:0]  s1_slot_ff;

   logic [WORD_W-1:0]  ram_rd_data;
   logic [WORD_W-1:0]  rd_word;
   logic [WORD_W-1:0]  wr_word;
   logic [PIXEL_W-1:0] rd_lane [LINES];
   logic [PIXEL_W-1:0] new_col [LINES];
   logic               fwd_hit_ff;
   logic [WORD_W-1:0]  fwd_word_ff;

   logic [PIXEL_W-1:0] window_ff [WSIZE][WSIZE];

   logic signed [PROD_W-1:0] prod_in [CB][4];
   logic signed [PROD_W-1:0] prod_ff [CB][4];
   logic [PIXEL_W-1:0]       centre_ff;
   logic [CB-1:0]            code_bits;

   logic [CODE_W-1:0] fifo_code_ff [FIFO_DEPTH];
   logic              fifo_end_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0] fifo_wr_ff;
   logic [FPTR_W-1:0] fifo_rd_ff;
   logic [PEND_W-1:0] fifo_count_ff;
   logic [PEND_W-1:0] pending_ff;

   // ---------------------------------------------------------------- config
   always_comb begin
      if (csr_wdata == '0) begin
         width_last_in = '0;
      end else if (WEXT'(csr_wdata) > WEXT'(MAX_WIDTH)) begin
         width_last_in = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_last_in = COL_W'(csr_wdata - 1'b1);
      end
      if (csr_wdata == '0) begin
         height_last_in = '0;
      end else if (csr_wdata > CFG_W'(MAX_HEIGHT)) begin
         height_last_in = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         height_last_in = ROW_W'(csr_wdata - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= COL_W'(RST_WL);
         height_last_ff <= ROW_W'(RST_HL);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  width_last_ff  <= width_last_in;
            CSR_IMAGE_HEIGHT: height_last_ff <= height_last_in;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- counters
   assign accept   = req_valid && req_ready;
   assign col_wrap = (col_ff >= width_last_ff);
   assign row_wrap = (row_ff >= height_last_ff);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               slot_in = (slot_ff == SLOT_W'(LINES - 1)) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_in.valid     = accept;
      s1_in.emit      = (col_ff >= COL_W'(LINES)) && (row_ff >= ROW_W'(LINES));
      s1_in.frame_end = col_wrap && row_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         slot_ff    <= '0;
         s1_ff      <= '0;
         s2_ff      <= '0;
         s3_ff      <= '0;
         fwd_hit_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         slot_ff    <= slot_in;
         s1_ff      <= s1_in;
         s2_ff      <= s1_ff;
         s3_ff      <= s2_ff;
         fwd_hit_ff <= accept && s1_ff.valid && (col_ff == s1_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_pixel;
         s1_col_ff  <= col_ff;
         s1_slot_ff <= slot_ff;
      end
      fwd_word_ff <= wr_word;
   end

   // ---------------------------------------------------------------- line RAM
   clbp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_word = fwd_hit_ff ? fwd_word_ff : ram_rd_data;

   for (genvar l = 0; l < LINES; l++) begin : g_lane
      logic [SLOT_W:0]  lane_sum;
      logic [SLOT_W-1:0] lane_idx;
      assign rd_lane[l] = rd_word[l*PIXEL_W +: PIXEL_W];
      assign wr_word[l*PIXEL_W +: PIXEL_W] =
         (s1_slot_ff == SLOT_W'(l)) ? s1_px_ff : rd_lane[l];
      // window row l takes the buffered row 2*RADIUS - l lines above the current one
      assign lane_sum = {1'b0, s1_slot_ff} + (SLOT_W + 1)'(l);
      assign lane_idx = (lane_sum >= (SLOT_W + 1)'(LINES)) ?
                        SLOT_W'(lane_sum - (SLOT_W + 1)'(LINES)) : SLOT_W'(lane_sum);
      assign new_col[l] = rd_lane[lane_idx];
   end

   // ---------------------------------------------------------------- window
   always_ff @(posedge clock) begin
      if (s1_ff.valid) begin
         for (int i = 0; i < WSIZE; i++) begin
            for (int k = 0; k < WSIZE - 1; k++) begin
               window_ff[i][k] <= window_ff[i][k+1];
            end
         end
         for (int i = 0; i < LINES; i++) begin
            window_ff[i][WSIZE-1] <= new_col[i];
         end
         window_ff[WSIZE-1][WSIZE-1] <= s1_px_ff;
      end
   end

   // ---------------------------------------------------------------- sampling
   for (genvar n = 0; n < CB; n++) begin : g_nbr
      localparam int           QUAD = (4 * n) / NEIGHBORS;
      localparam int           REM  = (4 * n) % NEIGHBORS;
      localparam logic [63:0]  PHI  = (HALF_PI_Q30 * 64'(REM)) / NEIGHBORS;
      localparam lbp_geom_type G    = lbp_geom(PHI, QUAD, RADIUS);
      localparam int RFY = RADIUS + int'(G.fy);
      localparam int RCY = RADIUS + int'(G.cy);
      localparam int RFX = RADIUS + int'(G.fx);
      localparam int RCX = RADIUS + int'(G.cx);
      localparam logic signed [PROD_W-1:0] W1 = PROD_W'($signed(G.w1));
      localparam logic signed [PROD_W-1:0] W2 = PROD_W'($signed(G.w2));
      localparam logic signed [PROD_W-1:0] W3 = PROD_W'($signed(G.w3));
      localparam logic signed [PROD_W-1:0] W4 = PROD_W'($signed(G.w4));

      logic signed [SUM_W-1:0] total;

      assign prod_in[n][0] = W1 * $signed(PROD_W'(window_ff[RFY][RFX]));
      assign prod_in[n][1] = W2 * $signed(PROD_W'(window_ff[RFY][RCX]));
      assign prod_in[n][2] = W3 * $signed(PROD_W'(window_ff[RCY][RFX]));
      assign prod_in[n][3] = W4 * $signed(PROD_W'(window_ff[RCY][RCX]));

      assign total = SUM_W'(prod_ff[n][0]) + SUM_W'(prod_ff[n][1]) +
                     SUM_W'(prod_ff[n][2]) + SUM_W'(prod_ff[n][3]);
      assign code_bits[n] = (total >= $signed(SUM_W'({centre_ff, 8'b0})));
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      centre_ff <= window_ff[RADIUS][RADIUS];
   end

   // ---------------------------------------------------------------- output
   assign push = s3_ff.valid && s3_ff.emit;
   assign drop = s3_ff.valid && !s3_ff.emit;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_code_ff[fifo_wr_ff] <= CODE_W'(code_bits);
         fifo_end_ff[fifo_wr_ff]  <= s3_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ff    <= '0;
         fifo_rd_ff    <= '0;
         fifo_count_ff <= '0;
         pending_ff    <= '0;
      end else begin
         if (push) begin
            fifo_wr_ff <= fifo_wr_ff + 1'b1;
         end
         if (pop) begin
            fifo_rd_ff <= fifo_rd_ff + 1'b1;
         end
         fifo_count_ff <= fifo_count_ff + PEND_W'(push) - PEND_W'(pop);
         // every transaction holds a credit until its result leaves or it proves a border pixel
         pending_ff    <= pending_ff + PEND_W'(accept) - PEND_W'(pop) - PEND_W'(drop);
      end
   end

   assign req_ready     = (pending_ff < PEND_W'(FIFO_DEPTH));
   assign rsp_valid     = (fifo_count_ff != '0);
   assign rsp_code      = fifo_code_ff[fifo_rd_ff];
   assign rsp_frame_end = fifo_end_ff[fifo_rd_ff];

   // ---------------------------------------------------------------- checks
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PEND_W'(FIFO_DEPTH))
      else $error("credit count above FIFO depth");

   a_fifo_in_credit: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= pending_ff)
      else $error("FIFO holds entries without credit");

   a_fwd_with_write: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_ff.valid)
      else $error("forwarded word without a pending line RAM access");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid)
      else $error("pushed result not visible on response channel");

endmodule

[rtl/clbp_ram.sv]
// ----------------------------------------------------------------------------
// clbp_ram
// Simple dual-port RAM: one write port, one read port with registered data
// (read returns the old contents on a same-address write).
// ----------------------------------------------------------------------------
module clbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
